// ----- rtl/rcfp_pkg.sv -----
// Package: constants, types and decode helpers for the remote command frame parser.
package rcfp_pkg;

	localparam int MAX_FRAME = 64;
	localparam int POS_W     = $clog2(MAX_FRAME + 1);

	typedef logic [7:0]       byte_t;
	typedef logic [1:0]       speed_t;
	typedef logic [2:0]       gain_idx_t;
	typedef logic [3:0]       dir_t;
	typedef logic [POS_W-1:0] pos_t;

	localparam byte_t BYTE_OPEN       = 8'h7B;
	localparam byte_t BYTE_CLOSE      = 8'h7D;
	localparam byte_t BYTE_REPORT     = 8'h50;
	localparam byte_t BYTE_HIGH_SPEED = 8'h59;
	localparam byte_t BYTE_LOW_SPEED  = 8'h58;
	localparam byte_t BYTE_KEY_FIRST  = 8'h41;
	localparam byte_t BYTE_KEY_LAST   = 8'h48;
	localparam byte_t BYTE_HOLD       = 8'd10;
	localparam byte_t GAIN_ID_FIRST   = 8'h30;
	localparam byte_t GAIN_ID_LAST    = 8'h35;

	localparam speed_t SPEED_LOW  = 2'd1;
	localparam speed_t SPEED_HIGH = 2'd2;

	// direction bits: 0 forward, 1 back, 2 left, 3 right
	localparam dir_t DIR_STOP = 4'b0000;
	localparam dir_t DIR_FWD  = 4'b0001;
	localparam dir_t DIR_BACK = 4'b0010;
	localparam dir_t DIR_LEFT = 4'b0100;
	localparam dir_t DIR_RGHT = 4'b1000;

	localparam logic signed [36:0] DIGIT_ZERO = 37'sd48;
	localparam logic signed [36:0] ACC_MAX    = 37'sd2147483647;
	localparam logic signed [36:0] ACC_MIN    = -37'sd2147483648;

	function automatic dir_t drive_code(input logic [3:0] c);
		dir_t d;
		case (c)
			4'd1:             d = DIR_FWD;
			4'd5:             d = DIR_BACK;
			4'd2, 4'd3, 4'd4: d = DIR_RGHT;
			4'd6, 4'd7, 4'd8: d = DIR_LEFT;
			default:          d = DIR_STOP;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/rcfp_if.sv -----
// Interfaces: received byte channel and decoded command channel.
interface rcfp_rx_if;
	import rcfp_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfp_cmd_if;
	import rcfp_pkg::*;
	logic               valid;
	logic               ready;
	logic               go_forward;
	logic               go_back;
	logic               go_left;
	logic               go_right;
	speed_t             speed_mode;
	logic               gain_write;
	gain_idx_t          gain_index;
	logic signed [31:0] gain_value;
	logic               report_request;
	modport source (output valid, output go_forward, output go_back, output go_left,
		output go_right, output speed_mode, output gain_write, output gain_index,
		output gain_value, output report_request, input ready);
	modport sink (input valid, input go_forward, input go_back, input go_left,
		input go_right, input speed_mode, input gain_write, input gain_index,
		input gain_value, input report_request, output ready);
endinterface

// ----- rtl/remote_command_frame_parser_core.sv -----
// Top level: remote command frame parser (drive decode and gain frame parsing).
// Each received byte on rx yields exactly one request on cmd, in order. A byte is
// taken every cycle while cmd keeps up; a byte passes the input register, then the
// result register, and its request is held on cmd until taken. The frame update is
// combinational: the decimal fold acc*10 + (byte - 48) is a shift-add with a
// saturating compare. Drive flags and speed mode reflect state after the byte;
// gain_index and gain_value are zero unless gain_write is set.
module remote_command_frame_parser_core (
	input  logic clk,
	input  logic arst_n,
	rcfp_rx_if.sink    rx,
	rcfp_cmd_if.source cmd
);
	import rcfp_pkg::*;

	byte_t              rx_s1;
	logic               v_s1;
	logic               out_v_q;
	logic               adv_out;
	logic               load;

	logic               phase_q;
	pos_t               pos_q;
	byte_t              id_q;
	byte_t              fourth_q;
	logic signed [31:0] acc_q;
	dir_t               dir_q;
	speed_t             speed_q;

	logic               wr_q;
	gain_idx_t          idx_q;
	logic signed [31:0] val_q;
	logic               rep_q;

	byte_t              b;
	dir_t               dir_d;
	speed_t             speed_d;
	logic               is_close;
	logic               phase_eff;
	logic               take;
	logic               id_ok;
	logic               is_rep;
	logic signed [36:0] acc_x;
	logic signed [36:0] fold_t;
	logic signed [31:0] fold_sat;

	assign adv_out  = !out_v_q || cmd.ready;
	assign rx.ready = !v_s1 || adv_out;
	assign load     = v_s1 && adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_s1 <= rx.rx_byte;
		end
	end

	assign b = rx_s1;

	always_comb begin
		dir_d = dir_q;
		if (b > BYTE_HOLD) begin
			if (b >= BYTE_KEY_FIRST && b <= BYTE_KEY_LAST) begin
				dir_d = drive_code(b[3:0]);
			end else begin
				dir_d = DIR_STOP;
			end
		end else if (b < BYTE_HOLD) begin
			dir_d = drive_code(b[3:0]);
		end

		speed_d = speed_q;
		if (b == BYTE_HIGH_SPEED) begin
			speed_d = SPEED_HIGH;
		end else if (b == BYTE_LOW_SPEED) begin
			speed_d = SPEED_LOW;
		end
	end

	assign is_close  = (b == BYTE_CLOSE);
	assign phase_eff = phase_q || (b == BYTE_OPEN);
	assign take      = phase_eff && (pos_q < POS_W'(MAX_FRAME));
	assign id_ok     = (id_q >= GAIN_ID_FIRST) && (id_q <= GAIN_ID_LAST);
	assign is_rep    = (fourth_q == BYTE_REPORT);

	// acc*10 as (acc<<3) + (acc<<1), then saturate to 32 bits signed
	assign acc_x  = {{5{acc_q[31]}}, acc_q};
	assign fold_t = (acc_x <<< 3) + (acc_x <<< 1) + $signed({29'd0, b}) - DIGIT_ZERO;

	always_comb begin
		if (fold_t > ACC_MAX) begin
			fold_sat = 32'sh7FFF_FFFF;
		end else if (fold_t < ACC_MIN) begin
			fold_sat = 32'sh8000_0000;
		end else begin
			fold_sat = fold_t[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			phase_q  <= 1'b0;
			pos_q    <= '0;
			id_q     <= '0;
			fourth_q <= '0;
			acc_q    <= '0;
			dir_q    <= DIR_STOP;
			speed_q  <= SPEED_HIGH;
		end else begin
			if (adv_out) begin
				out_v_q <= v_s1;
			end
			if (load) begin
				dir_q   <= dir_d;
				speed_q <= speed_d;
				if (is_close) begin
					phase_q  <= 1'b0;
					pos_q    <= '0;
					id_q     <= '0;
					fourth_q <= '0;
					acc_q    <= '0;
				end else begin
					phase_q <= phase_eff;
					if (take) begin
						if (pos_q == POS_W'(1)) begin
							id_q <= b;
						end
						if (pos_q == POS_W'(3)) begin
							fourth_q <= b;
						end
						if (pos_q >= POS_W'(3)) begin
							acc_q <= fold_sat;
						end
						pos_q <= pos_q + POS_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rep_q <= is_close && is_rep;
			wr_q  <= is_close && !is_rep && id_ok;
			if (is_close && !is_rep && id_ok) begin
				idx_q <= id_q[2:0];
				val_q <= acc_q;
			end else begin
				idx_q <= '0;
				val_q <= '0;
			end
		end
	end

	assign cmd.valid          = out_v_q;
	assign cmd.go_forward     = dir_q[0];
	assign cmd.go_back        = dir_q[1];
	assign cmd.go_left        = dir_q[2];
	assign cmd.go_right       = dir_q[3];
	assign cmd.speed_mode     = speed_q;
	assign cmd.gain_write     = wr_q;
	assign cmd.gain_index     = idx_q;
	assign cmd.gain_value     = val_q;
	assign cmd.report_request = rep_q;

`ifndef ASSERT_OFF
	a_wr_rep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> !(cmd.gain_write && cmd.report_request))
		else $error("gain write and report request in one request");

	a_gain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && !cmd.gain_write) |-> (cmd.gain_index == '0 && cmd.gain_value == '0))
		else $error("gain fields nonzero without gain write");

	a_speed_set: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_q == SPEED_LOW) || (speed_q == SPEED_HIGH))
		else $error("speed mode lost");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_FRAME))
		else $error("frame position past limit");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_out) |=> (v_s1 && $stable(rx_s1)))
		else $error("input stage dropped a byte under stall");
`endif

endmodule
